// File: hw/rtl/ata_pkg.sv
// Shared types, constants and the arctangent table of the accelerometer tilt averager.
package ata_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int ANGLE_W        = 12;
	localparam int ERR_W          = 7;
	localparam logic [ERR_W-1:0] ERR_LIMIT = 7'd100;

	localparam int DEF_DEPTH_LOG2 = 3;
	localparam int DEF_DEPTH      = 8;
	localparam int DEF_OUT_SCALE  = 1024;

	// CORDIC: 30 vectoring steps, angle units where pi = 2^31
	localparam int CORDIC_STEPS   = 30;
	localparam int IDX_W          = 5;
	localparam int LUT_W          = 30;
	localparam int ANG_FRAC       = 31;
	localparam int ANG_W          = 34;
	localparam int PRESCALE       = 14;
	localparam int SCALE_W        = 16;
	localparam int PROD_W         = ANG_W + SCALE_W;
	localparam logic signed [ANG_W-1:0] ANG_PI   = 34'sh0_8000_0000;
	localparam logic signed [ANG_W-1:0] ANG_HALF = 34'sh0_4000_0000;

	typedef struct packed {
		logic                       read_ok;
		logic signed [SAMPLE_W-1:0] acc_x;
		logic signed [SAMPLE_W-1:0] acc_y;
		logic signed [SAMPLE_W-1:0] acc_z;
	} sample_t;

	typedef struct packed {
		logic signed [ANGLE_W-1:0] roll_angle;
		logic signed [ANGLE_W-1:0] pitch_angle;
		logic                      read_error;
		logic                      disabled;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic             capture;
		logic             err_inc;
		logic             ring_rd;
		logic             sum_upd;
		logic             cordic_load;
		logic             cordic_step;
		logic [IDX_W-1:0] step_idx;
		logic             mul;
		logic             scale;
		logic             out_load;
		logic             read_error;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic disabled;
	} status_t;

	function automatic logic [LUT_W-1:0] atan_lut(input logic [IDX_W-1:0] idx);
		logic [LUT_W-1:0] v;
		unique case (idx)
			5'd0:    v = 30'h20000000;
			5'd1:    v = 30'h12E4051E;
			5'd2:    v = 30'h09FB385B;
			5'd3:    v = 30'h051111D4;
			5'd4:    v = 30'h028B0D43;
			5'd5:    v = 30'h0145D7E1;
			5'd6:    v = 30'h00A2F61E;
			5'd7:    v = 30'h00517C55;
			5'd8:    v = 30'h0028BE53;
			5'd9:    v = 30'h00145F2F;
			5'd10:   v = 30'h000A2F98;
			5'd11:   v = 30'h000517CC;
			5'd12:   v = 30'h00028BE6;
			5'd13:   v = 30'h000145F3;
			5'd14:   v = 30'h0000A2F9;
			5'd15:   v = 30'h0000517C;
			5'd16:   v = 30'h000028BE;
			5'd17:   v = 30'h0000145F;
			5'd18:   v = 30'h00000A2F;
			5'd19:   v = 30'h00000517;
			5'd20:   v = 30'h0000028B;
			5'd21:   v = 30'h00000145;
			5'd22:   v = 30'h000000A2;
			5'd23:   v = 30'h00000051;
			5'd24:   v = 30'h00000028;
			5'd25:   v = 30'h00000014;
			5'd26:   v = 30'h0000000A;
			5'd27:   v = 30'h00000005;
			5'd28:   v = 30'h00000002;
			5'd29:   v = 30'h00000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/ata_ram.sv
// Generic single-port-write, registered-read RAM.
module ata_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/ata_cordic.sv
// One CORDIC vectoring lane: atan2(num, den), one iteration per step.
module ata_cordic #(
	parameter int MEAN_W = 19
) (
	input  logic                              clk,
	input  logic                              load,
	input  logic                              step,
	input  logic [ata_pkg::IDX_W-1:0]         idx,
	input  logic signed [MEAN_W-1:0]          num,
	input  logic signed [MEAN_W-1:0]          den,
	output logic signed [ata_pkg::ANG_W-1:0]  angle
);

	// headroom for the prescale, the CORDIC gain and the sqrt(2) of the vector length
	localparam int CW = MEAN_W + ata_pkg::PRESCALE + 3;

	logic signed [CW-1:0]              cx_q, cy_q;
	logic signed [CW-1:0]              cx_ext, cy_ext, cx_pre, cy_pre, dx, dy;
	logic signed [ata_pkg::ANG_W-1:0]  a_q, a_pre, t;
	logic                              hold_q, hold_pre;

	always_comb begin
		cx_ext   = CW'(den);
		cy_ext   = CW'(num);
		cx_pre   = cx_ext <<< ata_pkg::PRESCALE;
		cy_pre   = cy_ext <<< ata_pkg::PRESCALE;
		a_pre    = '0;
		hold_pre = 1'b0;
		priority if (num == '0) begin
			a_pre    = (den < 0) ? ata_pkg::ANG_PI : '0;
			hold_pre = 1'b1;
		end else if (den == '0) begin
			a_pre    = (num > 0) ? ata_pkg::ANG_HALF : -ata_pkg::ANG_HALF;
			hold_pre = 1'b1;
		end else if (den < 0) begin
			// left half plane: rotate by pi first
			a_pre  = (num > 0) ? ata_pkg::ANG_PI : -ata_pkg::ANG_PI;
			cx_pre = -cx_pre;
			cy_pre = -cy_pre;
		end else begin
			a_pre = '0;
		end
	end

	assign dx = cy_q >>> idx;
	assign dy = cx_q >>> idx;
	assign t  = ata_pkg::ANG_W'(ata_pkg::atan_lut(idx));

	always_ff @(posedge clk) begin
		if (load) begin
			cx_q   <= cx_pre;
			cy_q   <= cy_pre;
			a_q    <= a_pre;
			hold_q <= hold_pre;
		end else if (step && !hold_q) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				a_q  <= a_q + t;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				a_q  <= a_q - t;
			end
		end
	end

	assign angle = a_q;

endmodule

// File: hw/rtl/ata_datapath.sv
// Datapath: sample ring, running sums, two CORDIC lanes, scaling, error count, result register.
module ata_datapath #(
	parameter int DEPTH_LOG2 = ata_pkg::DEF_DEPTH_LOG2,
	parameter int DEPTH      = ata_pkg::DEF_DEPTH,
	parameter int OUT_SCALE  = ata_pkg::DEF_OUT_SCALE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ata_pkg::cmd_t     cmd,
	input  ata_pkg::sample_t  sample,
	output ata_pkg::result_t  result,
	output ata_pkg::status_t  status
);

	localparam int AW     = $clog2(DEPTH);
	localparam int SW     = ata_pkg::SAMPLE_W;
	localparam int SUM_W  = SW + $clog2(DEPTH) + 1;
	localparam int RING_W = 3 * SW;
	localparam logic signed [ata_pkg::SCALE_W-1:0] SCALE_C = ata_pkg::SCALE_W'(OUT_SCALE);
	localparam logic signed [ata_pkg::PROD_W-1:0]  BIAS =
		ata_pkg::PROD_W'((64'sd1 <<< ata_pkg::ANG_FRAC) - 64'sd1);

	ata_pkg::sample_t  sample_q;
	ata_pkg::result_t  result_q;

	logic [AW-1:0]                  pos_q, pos_next;
	logic [DEPTH-1:0]               valid_q;
	logic [RING_W-1:0]              ring_rdata, ring_wdata;
	logic signed [SW-1:0]           old_x, old_y, old_z;
	logic signed [SUM_W-1:0]        sums_q [3];
	logic signed [SUM_W-1:0]        mean_x, mean_y, mean_z;
	logic [ata_pkg::ERR_W-1:0]      err_cnt_q;
	logic signed [ata_pkg::ANG_W-1:0]   roll_a, pitch_a;
	logic signed [ata_pkg::PROD_W-1:0]  roll_prod_s1, pitch_prod_s1;
	logic signed [ata_pkg::PROD_W-1:0]  roll_b, pitch_b, roll_sh, pitch_sh;
	logic signed [ata_pkg::ANGLE_W-1:0] last_roll_q, last_pitch_q;

	assign pos_next   = (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
	assign ring_wdata = {sample_q.acc_z, sample_q.acc_y, sample_q.acc_x};

	ata_ram #(
		.WIDTH (RING_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.sum_upd),
		.waddr (pos_q),
		.wdata (ring_wdata),
		.re    (cmd.ring_rd),
		.raddr (pos_next),
		.rdata (ring_rdata)
	);

	// never-written slots read as zero
	assign old_x = valid_q[pos_q] ? ring_rdata[SW-1:0]      : '0;
	assign old_y = valid_q[pos_q] ? ring_rdata[2*SW-1:SW]   : '0;
	assign old_z = valid_q[pos_q] ? ring_rdata[3*SW-1:2*SW] : '0;

	assign mean_x = sums_q[0] >>> DEPTH_LOG2;
	assign mean_y = sums_q[1] >>> DEPTH_LOG2;
	assign mean_z = sums_q[2] >>> DEPTH_LOG2;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			valid_q   <= '0;
			sums_q[0] <= '0;
			sums_q[1] <= '0;
			sums_q[2] <= '0;
			err_cnt_q <= '0;
		end else begin
			if (cmd.ring_rd) begin
				pos_q <= pos_next;
			end
			if (cmd.sum_upd) begin
				valid_q[pos_q] <= 1'b1;
				sums_q[0] <= sums_q[0] - SUM_W'(old_x) + SUM_W'(sample_q.acc_x);
				sums_q[1] <= sums_q[1] - SUM_W'(old_y) + SUM_W'(sample_q.acc_y);
				sums_q[2] <= sums_q[2] - SUM_W'(old_z) + SUM_W'(sample_q.acc_z);
			end
			if (cmd.err_inc) begin
				err_cnt_q <= err_cnt_q + 1'b1;
			end
		end
	end

	ata_cordic #(.MEAN_W(SUM_W)) u_roll (
		.clk   (clk),
		.load  (cmd.cordic_load),
		.step  (cmd.cordic_step),
		.idx   (cmd.step_idx),
		.num   (mean_y),
		.den   (mean_z),
		.angle (roll_a)
	);

	ata_cordic #(.MEAN_W(SUM_W)) u_pitch (
		.clk   (clk),
		.load  (cmd.cordic_load),
		.step  (cmd.cordic_step),
		.idx   (cmd.step_idx),
		.num   (mean_x),
		.den   (mean_z),
		.angle (pitch_a)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			roll_prod_s1  <= roll_a * SCALE_C;
			pitch_prod_s1 <= pitch_a * SCALE_C;
		end
	end

	// divide by 2^31, truncating toward zero
	assign roll_b   = (roll_prod_s1 < 0)  ? roll_prod_s1 + BIAS  : roll_prod_s1;
	assign pitch_b  = (pitch_prod_s1 < 0) ? pitch_prod_s1 + BIAS : pitch_prod_s1;
	assign roll_sh  = roll_b >>> ata_pkg::ANG_FRAC;
	assign pitch_sh = pitch_b >>> ata_pkg::ANG_FRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_roll_q  <= '0;
			last_pitch_q <= '0;
		end else if (cmd.scale) begin
			last_roll_q  <= roll_sh[ata_pkg::ANGLE_W-1:0];
			last_pitch_q <= pitch_sh[ata_pkg::ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_q.roll_angle  <= last_roll_q;
			result_q.pitch_angle <= last_pitch_q;
			result_q.read_error  <= cmd.read_error;
			result_q.disabled    <= status.disabled;
		end
	end

	assign status.disabled = (err_cnt_q >= ata_pkg::ERR_LIMIT);
	assign result          = result_q;

endmodule

// File: hw/rtl/ata_ctrl.sv
// Controller: sequences ring update, CORDIC iterations, scaling and result handoff.
module ata_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              read_ok,
	output logic              sample_stall,
	output logic              result_valid,
	input  logic              result_stall,
	input  ata_pkg::status_t  status,
	output ata_pkg::cmd_t     cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SUM   = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_ITER  = 7'b0001000,
		ST_MUL   = 7'b0010000,
		ST_SCALE = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	localparam logic [ata_pkg::IDX_W-1:0] LAST_IDX = ata_pkg::IDX_W'(ata_pkg::CORDIC_STEPS - 1);

	state_t                     state_q, state_next;
	logic [ata_pkg::IDX_W-1:0]  idx_q;
	logic                       rerr_q;
	logic                       result_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.step_idx   = idx_q;
		cmd.read_error = rerr_q;
		state_next     = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					cmd.capture = 1'b1;
					priority if (status.disabled) begin
						state_next = ST_DONE;
					end else if (!read_ok) begin
						cmd.err_inc = 1'b1;
						state_next  = ST_DONE;
					end else begin
						cmd.ring_rd = 1'b1;
						state_next  = ST_SUM;
					end
				end
			end
			ST_SUM: begin
				cmd.sum_upd = 1'b1;
				state_next  = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.cordic_load = 1'b1;
				state_next      = ST_ITER;
			end
			ST_ITER: begin
				cmd.cordic_step = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_next = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale  = 1'b1;
				state_next = ST_DONE;
			end
			ST_DONE: begin
				// wait until the result register is free or being emptied
				if (!result_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			idx_q          <= '0;
			rerr_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.cordic_load) begin
				idx_q <= '0;
			end else if (cmd.cordic_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.capture) begin
				rerr_q <= cmd.err_inc;
			end
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

endmodule

// File: hw/rtl/accel_tilt_averager.sv
// Top level of the accelerometer tilt averager: controller, datapath and checks.
// Each item accepted with a good read while enabled enters a DEPTH-entry ring whose running
// sums give boxcar means per axis; roll = atan2(mean_y, mean_z) and pitch = atan2(mean_x,
// mean_z) come out scaled to +-OUT_SCALE for pi, within one LSB. A good read passes through
// ring update, CORDIC load, the 30-step CORDIC loop, multiply and scale before its result is
// loaded; roll and pitch are computed side by side in two lanes. A failed read, or any item
// once disabled, goes straight to the result load and repeats the last angles. The block holds
// one item at a time; the result register lets the next item in while a result waits to be
// taken. After 100 failed reads disabled stays set and the angles stay frozen until reset.
module accel_tilt_averager #(
	parameter int DEPTH_LOG2 = ata_pkg::DEF_DEPTH_LOG2,
	parameter int DEPTH      = ata_pkg::DEF_DEPTH,
	parameter int OUT_SCALE  = ata_pkg::DEF_OUT_SCALE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  ata_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_stall,
	output ata_pkg::result_t  result
);

	ata_pkg::cmd_t     cmd;
	ata_pkg::status_t  status;

	ata_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.read_ok      (sample.read_ok),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	ata_datapath #(
		.DEPTH_LOG2 (DEPTH_LOG2),
		.DEPTH      (DEPTH),
		.OUT_SCALE  (OUT_SCALE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (sample),
		.result (result),
		.status (status)
	);

	// once disabled, the block stays disabled
	a_disabled_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.disabled |=> status.disabled)
		else $error("disabled flag dropped");

	// one item at a time: an accepted item closes the input the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("input accepted while an item is in progress");

	a_result_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.disabled) |-> status.disabled)
		else $error("result reports disabled but block is enabled");

endmodule
